/* src/p2bcd_pkg.sv */
// Shared constants, types and the gamma ROM of the pixel to bit-plane writer.
// Used by every module of the block; depends on nothing else.
package p2bcd_pkg;

    localparam int PANEL_WIDTH_DEF     = 32;
    localparam int PANEL_HEIGHT_DEF    = 32;
    localparam int FRAME_COUNT_DEF     = 14;
    localparam int FRAME_BYTES_DEF     = 72;
    localparam int ROW_BLOCK_BYTES_DEF = 1008;

    localparam int COORD_W  = 6;
    localparam int COLOR_W  = 8;
    localparam int ADDR_W   = 14;
    localparam int GAMMA_W  = 14;
    localparam int BRIGHT_W = 9;
    localparam int COL_W    = 6;
    localparam int ROW_W    = 5;
    localparam int PROD_W   = COLOR_W + BRIGHT_W;

    // Each frame of a row block starts with two header bytes.
    localparam int FRAME_HEADER_BYTES = 2;

    localparam int GAMMA_MAX   = 16383;
    localparam int GAMMA_DEPTH = 256;
    localparam int BIG_W       = 256;

    localparam logic [BRIGHT_W-1:0] BRIGHT_FULL  = 9'd256;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 9'd256;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_BRIGHTNESS = 1'b0;

    typedef logic [GAMMA_W-1:0] t_gamma;
    typedef t_gamma t_gamma_rom [GAMMA_DEPTH];

    typedef struct packed {
        t_gamma             gamma_red;
        t_gamma             gamma_green;
        t_gamma             gamma_blue;
        logic [ADDR_W-1:0]  base_addr;
    } t_plane_job;

    // Entry idx is the largest v with (2v-1)^5 * 255^14 <= (2*16383)^5 * idx^14,
    // which is the exact round-to-nearest of 16383 * (idx/255)^2.8.
    function automatic t_gamma gamma_entry(input int unsigned idx);
        logic [BIG_W-1:0] rhs;
        logic [BIG_W-1:0] lhs;
        int unsigned      lo;
        int unsigned      hi;
        int unsigned      mid;
        int               k;
        int               step;
        rhs = BIG_W'(1);
        for (k = 0; k < 5; k++) begin
            rhs = rhs * BIG_W'(2 * GAMMA_MAX);
        end
        for (k = 0; k < 14; k++) begin
            rhs = rhs * BIG_W'(idx);
        end
        lo = 0;
        hi = GAMMA_MAX;
        for (step = 0; step < 16; step++) begin
            if (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                lhs = BIG_W'(1);
                for (k = 0; k < 5; k++) begin
                    lhs = lhs * BIG_W'(2 * mid - 1);
                end
                for (k = 0; k < 14; k++) begin
                    lhs = lhs * BIG_W'(255);
                end
                if (lhs <= rhs) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
        end
        return GAMMA_W'(lo);
    endfunction

    function automatic t_gamma_rom build_gamma();
        t_gamma_rom rom;
        int         i;
        for (i = 0; i < GAMMA_DEPTH; i++) begin
            rom[i] = gamma_entry(i);
        end
        return rom;
    endfunction

    localparam t_gamma_rom GAMMA_ROM = build_gamma();

endpackage

/* src/p2bcd_pixel_if.sv */
// Request channel for pixel writes: valid/ready handshake plus pixel payload.
// Widths come from p2bcd_pkg.
interface p2bcd_pixel_if;
    logic                            valid;
    logic                            ready;
    logic [p2bcd_pkg::COORD_W-1:0]   pixel_x;
    logic [p2bcd_pkg::COORD_W-1:0]   pixel_y;
    logic [p2bcd_pkg::COLOR_W-1:0]   red;
    logic [p2bcd_pkg::COLOR_W-1:0]   green;
    logic [p2bcd_pkg::COLOR_W-1:0]   blue;

    modport source (output valid, pixel_x, pixel_y, red, green, blue, input ready);
    modport sink   (input valid, pixel_x, pixel_y, red, green, blue, output ready);
endinterface

/* src/p2bcd_plane_if.sv */
// Request channel for bit-plane byte writes: valid/ready handshake plus payload.
// Widths come from p2bcd_pkg.
interface p2bcd_plane_if;
    logic                          valid;
    logic                          ready;
    logic [p2bcd_pkg::ADDR_W-1:0]  plane_address;
    logic [2:0]                    plane_bits;
    logic                          last_plane;

    modport source (output valid, plane_address, plane_bits, last_plane, input ready);
    modport sink   (input valid, plane_address, plane_bits, last_plane, output ready);
endinterface

/* src/p2bcd_cfg.sv */
// APB-style configuration register file holding the brightness register.
// Depends on p2bcd_pkg.
module p2bcd_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [p2bcd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [p2bcd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [p2bcd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    output logic [p2bcd_pkg::BRIGHT_W-1:0]      o_brightness
);
    logic [p2bcd_pkg::BRIGHT_W-1:0] r_brightness;
    logic [p2bcd_pkg::BRIGHT_W-1:0] n_brightness;
    logic [0:0]                     w_index;
    logic                           w_write;

    assign w_index = paddr[p2bcd_pkg::APB_ADDR_W-1:2];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        n_brightness = r_brightness;
        if (w_write && (w_index == p2bcd_pkg::REG_BRIGHTNESS)) begin
            n_brightness = pwdata[p2bcd_pkg::BRIGHT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= p2bcd_pkg::BRIGHT_RESET;
        end else begin
            r_brightness <= n_brightness;
        end
    end

    always_comb begin
        case (w_index)
            p2bcd_pkg::REG_BRIGHTNESS: begin
                prdata = p2bcd_pkg::APB_DATA_W'(r_brightness);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_brightness = r_brightness;
endmodule

/* src/p2bcd_prep.sv */
// Front pipeline: panel check, mirror and fold, brightness scaling (stage 1),
// then gamma ROM lookup and row base address (stage 2). Depends on p2bcd_pkg.
module p2bcd_prep #(
    parameter int PANEL_WIDTH     = p2bcd_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT    = p2bcd_pkg::PANEL_HEIGHT_DEF,
    parameter int ROW_BLOCK_BYTES = p2bcd_pkg::ROW_BLOCK_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    p2bcd_pixel_if.sink                     i_pix,
    input  logic [p2bcd_pkg::BRIGHT_W-1:0]  i_brightness,
    output p2bcd_pkg::t_plane_job           o_job,
    output logic                            o_job_valid,
    input  logic                            i_job_ready
);
    localparam int COORD_W = p2bcd_pkg::COORD_W;
    localparam int COLOR_W = p2bcd_pkg::COLOR_W;
    localparam int COL_W   = p2bcd_pkg::COL_W;
    localparam int ROW_W   = p2bcd_pkg::ROW_W;
    localparam int ADDR_W  = p2bcd_pkg::ADDR_W;
    localparam int PROD_W  = p2bcd_pkg::PROD_W;

    logic                   r_s1_valid;
    logic [COL_W-1:0]       r_s1_col;
    logic [ROW_W-1:0]       r_s1_row;
    logic [COLOR_W-1:0]     r_s1_red;
    logic [COLOR_W-1:0]     r_s1_green;
    logic [COLOR_W-1:0]     r_s1_blue;
    logic                   r_s2_valid;
    p2bcd_pkg::t_plane_job  r_s2_job;

    logic                   w_s1_free;
    logic                   w_s2_free;
    logic                   w_on_panel;
    logic [COL_W-1:0]       w_col_m;
    logic [ROW_W-1:0]       w_row_m;
    logic [COL_W-1:0]       n_col;
    logic [ROW_W-1:0]       n_row;
    logic [p2bcd_pkg::BRIGHT_W-1:0] w_scale;
    logic [PROD_W-1:0]      w_prod_red;
    logic [PROD_W-1:0]      w_prod_green;
    logic [PROD_W-1:0]      w_prod_blue;
    p2bcd_pkg::t_plane_job  n_job;

    assign w_s2_free   = !r_s2_valid || i_job_ready;
    assign w_s1_free   = !r_s1_valid || w_s2_free;
    assign i_pix.ready = w_s1_free;

    assign w_on_panel = (i_pix.pixel_x < COORD_W'(PANEL_WIDTH)) &&
                        (i_pix.pixel_y < COORD_W'(PANEL_HEIGHT));

    // Mirror both axes; the upper half of the mirrored panel moves right by
    // one panel width, the lower half moves up by half the panel height.
    always_comb begin
        w_col_m = COL_W'(PANEL_WIDTH - 1) - i_pix.pixel_x;
        w_row_m = ROW_W'(PANEL_HEIGHT - 1) - i_pix.pixel_y[ROW_W-1:0];
        if (w_row_m < ROW_W'(PANEL_HEIGHT / 2)) begin
            n_col = w_col_m + COL_W'(PANEL_WIDTH);
            n_row = w_row_m;
        end else begin
            n_col = w_col_m;
            n_row = w_row_m - ROW_W'(PANEL_HEIGHT / 2);
        end
    end

    assign w_scale = (i_brightness > p2bcd_pkg::BRIGHT_FULL) ?
                     p2bcd_pkg::BRIGHT_FULL : i_brightness;
    assign w_prod_red   = PROD_W'(i_pix.red)   * PROD_W'(w_scale);
    assign w_prod_green = PROD_W'(i_pix.green) * PROD_W'(w_scale);
    assign w_prod_blue  = PROD_W'(i_pix.blue)  * PROD_W'(w_scale);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_valid <= i_pix.valid && w_on_panel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_free && i_pix.valid) begin
            r_s1_col   <= n_col;
            r_s1_row   <= n_row;
            r_s1_red   <= w_prod_red[COLOR_W+7:8];
            r_s1_green <= w_prod_green[COLOR_W+7:8];
            r_s1_blue  <= w_prod_blue[COLOR_W+7:8];
        end
    end

    always_comb begin
        n_job.gamma_red   = p2bcd_pkg::GAMMA_ROM[r_s1_red];
        n_job.gamma_green = p2bcd_pkg::GAMMA_ROM[r_s1_green];
        n_job.gamma_blue  = p2bcd_pkg::GAMMA_ROM[r_s1_blue];
        n_job.base_addr   = ADDR_W'(r_s1_row) * ADDR_W'(ROW_BLOCK_BYTES)
                          + ADDR_W'(p2bcd_pkg::FRAME_HEADER_BYTES)
                          + ADDR_W'(r_s1_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_free && r_s1_valid) begin
            r_s2_job <= n_job;
        end
    end

    assign o_job       = r_s2_job;
    assign o_job_valid = r_s2_valid;
endmodule

/* src/p2bcd_emit.sv */
// Frame sequencer: turns one prepared pixel into one byte write per modulation
// frame, straight from registers. Depends on p2bcd_pkg and p2bcd_plane_if.
module p2bcd_emit #(
    parameter int FRAME_COUNT = p2bcd_pkg::FRAME_COUNT_DEF,
    parameter int FRAME_BYTES = p2bcd_pkg::FRAME_BYTES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  p2bcd_pkg::t_plane_job   i_job,
    input  logic                    i_job_valid,
    output logic                    o_job_ready,
    p2bcd_plane_if.source           o_plane
);
    localparam int FW     = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int ADDR_W = p2bcd_pkg::ADDR_W;

    logic                   r_busy;
    logic                   r_last;
    logic [FW-1:0]          r_frame;
    logic [ADDR_W-1:0]      r_addr;
    p2bcd_pkg::t_gamma      r_gamma_red;
    p2bcd_pkg::t_gamma      r_gamma_green;
    p2bcd_pkg::t_gamma      r_gamma_blue;

    logic                   w_out_fire;
    logic                   w_load;
    logic                   w_step;

    assign w_out_fire  = r_busy && o_plane.ready;
    assign o_job_ready = !r_busy || (o_plane.ready && r_last);
    assign w_load      = i_job_valid && o_job_ready;
    assign w_step      = w_out_fire && !r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_last  <= 1'b0;
            r_frame <= '0;
        end else if (w_load) begin
            r_busy  <= 1'b1;
            r_last  <= (FRAME_COUNT == 1);
            r_frame <= '0;
        end else if (w_step) begin
            r_last  <= ((r_frame + FW'(1)) == FW'(FRAME_COUNT - 1));
            r_frame <= r_frame + FW'(1);
        end else if (w_out_fire) begin
            r_busy  <= 1'b0;
        end
    end

    // Gamma words shift right one bit per frame; frames past the word width
    // therefore carry zeros.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_addr        <= i_job.base_addr;
            r_gamma_red   <= i_job.gamma_red;
            r_gamma_green <= i_job.gamma_green;
            r_gamma_blue  <= i_job.gamma_blue;
        end else if (w_step) begin
            r_addr        <= r_addr + ADDR_W'(FRAME_BYTES);
            r_gamma_red   <= r_gamma_red >> 1;
            r_gamma_green <= r_gamma_green >> 1;
            r_gamma_blue  <= r_gamma_blue >> 1;
        end
    end

    assign o_plane.valid         = r_busy;
    assign o_plane.plane_address = r_addr;
    assign o_plane.plane_bits    = {r_gamma_red[0], r_gamma_green[0], r_gamma_blue[0]};
    assign o_plane.last_plane    = r_last;
endmodule

/* src/pixel_to_bcd_bitplane_writer_top.sv */
// Pixel to bit-plane writer for a binary code modulation LED matrix.
// Pixel writes enter on i_pix; byte writes for the frame buffer leave on o_plane.
// Brightness is written through the APB-style port (register 0, byte address 0).
// Each on-panel pixel produces FRAME_COUNT byte writes, one per modulation frame,
// in frame order, with last_plane set on the final one. Off-panel pixels are
// accepted and dropped without producing writes.
// The first write of a pixel passes the two front stages (panel check and
// scaling, then gamma lookup and base address) and the frame sequencer.
// The frame sequencer issues one write per cycle while o_plane.ready is high
// and starts the next pixel right after the current one's last write. The input
// takes a new pixel every cycle while the two front stages have room, so the
// next pixel waits prepared while the current one is being written out.
// When the receiver holds o_plane.ready low, the current write stays on the
// port unchanged and the front stages fill up, then i_pix.ready drops.
// Reset (synchronous, active low) empties the pipeline and sets brightness to
// 256 (full scale). Brightness should be changed only while the block is idle.
module pixel_to_bcd_bitplane_writer_top #(
    parameter int PANEL_WIDTH     = p2bcd_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT    = p2bcd_pkg::PANEL_HEIGHT_DEF,
    parameter int FRAME_COUNT     = p2bcd_pkg::FRAME_COUNT_DEF,
    parameter int FRAME_BYTES     = p2bcd_pkg::FRAME_BYTES_DEF,
    parameter int ROW_BLOCK_BYTES = p2bcd_pkg::ROW_BLOCK_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    p2bcd_pixel_if.sink                         i_pix,
    p2bcd_plane_if.source                       o_plane,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [p2bcd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [p2bcd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [p2bcd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    logic [p2bcd_pkg::BRIGHT_W-1:0] w_brightness;
    p2bcd_pkg::t_plane_job          w_job;
    logic                           w_job_valid;
    logic                           w_job_ready;

    p2bcd_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_brightness (w_brightness)
    );

    p2bcd_prep #(
        .PANEL_WIDTH     (PANEL_WIDTH),
        .PANEL_HEIGHT    (PANEL_HEIGHT),
        .ROW_BLOCK_BYTES (ROW_BLOCK_BYTES)
    ) u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (i_pix),
        .i_brightness (w_brightness),
        .o_job        (w_job),
        .o_job_valid  (w_job_valid),
        .i_job_ready  (w_job_ready)
    );

    p2bcd_emit #(
        .FRAME_COUNT (FRAME_COUNT),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job),
        .i_job_valid (w_job_valid),
        .o_job_ready (w_job_ready),
        .o_plane     (o_plane)
    );

    // Within one pixel, consecutive writes follow each other with no gap and
    // step the address by one frame.
    a_frame_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_plane.valid && o_plane.ready && !o_plane.last_plane |=>
            o_plane.valid &&
            (o_plane.plane_address ==
             $past(o_plane.plane_address) + p2bcd_pkg::ADDR_W'(FRAME_BYTES)))
        else $error("frame write sequence broken");

    // A prepared pixel waiting for the sequencer must not change.
    a_job_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_valid && !w_job_ready |=> w_job_valid && $stable(w_job))
        else $error("prepared pixel lost or changed while stalled");

    // Reset restores full-scale brightness.
    a_bright_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> w_brightness == p2bcd_pkg::BRIGHT_RESET)
        else $error("brightness not restored by reset");
endmodule
